FILE: rtl/dcg_pkg.sv
// shared constants, types and reciprocal tables for the chs geometry calculator
`timescale 1ns / 1ps

package dcg_pkg;

    // saturated sector count and constant-divider widths
    localparam int unsigned SEC_W        = 28;
    localparam int unsigned QUO_W        = 24;
    localparam int unsigned CH_W         = 20;
    localparam int unsigned RECIP_W      = 32;
    localparam int unsigned RECIP_SHIFT  = 36;
    localparam int unsigned PROD_W       = SEC_W + RECIP_W;

    // divider by the head count (only used below 16 heads, cylinder-heads under 2^14)
    localparam int unsigned HCH_W        = 14;
    localparam int unsigned HRECIP_W     = 19;
    localparam int unsigned HRECIP_SHIFT = 20;
    localparam int unsigned HPROD_W      = HCH_W + HRECIP_W;

    localparam int unsigned HEADS_W      = 5;
    localparam int unsigned SPT_W        = 8;
    localparam int unsigned CYL_W        = 16;
    localparam int unsigned CPH_SHIFT    = 10;

    typedef logic [SEC_W-1:0]   t_sectors;
    typedef logic [QUO_W-1:0]   t_quot;
    typedef logic [CH_W-1:0]    t_cyl_heads;
    typedef logic [HEADS_W-1:0] t_heads;
    typedef logic [SPT_W-1:0]   t_spt;
    typedef logic [CYL_W-1:0]   t_cyl;

    localparam t_sectors MAX_SECTORS = SEC_W'(65535 * 16 * 255);
    localparam t_sectors BIG_SECTORS = SEC_W'(65535 * 16 * 63);

    localparam t_spt SPT_17  = 8'd17;
    localparam t_spt SPT_31  = 8'd31;
    localparam t_spt SPT_63  = 8'd63;
    localparam t_spt SPT_255 = 8'd255;

    localparam t_heads HEADS_MIN = 5'd4;
    localparam t_heads HEADS_MAX = 5'd16;

    // rounded-up reciprocals, exact for any dividend below 2^28
    localparam logic [RECIP_W-1:0] RECIP_17  =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd16) / 64'd17);
    localparam logic [RECIP_W-1:0] RECIP_31  =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd30) / 64'd31);
    localparam logic [RECIP_W-1:0] RECIP_63  =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd62) / 64'd63);
    localparam logic [RECIP_W-1:0] RECIP_255 =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd254) / 64'd255);

    // rounded-up 2^20 / heads, exact for dividends below 2^14
    function automatic logic [HRECIP_W-1:0] head_recip(input t_heads heads);
        logic [HRECIP_W-1:0] recip;
        case (heads)
            5'd4:    recip = 19'd262144;
            5'd5:    recip = 19'd209716;
            5'd6:    recip = 19'd174763;
            5'd7:    recip = 19'd149797;
            5'd8:    recip = 19'd131072;
            5'd9:    recip = 19'd116509;
            5'd10:   recip = 19'd104858;
            5'd11:   recip = 19'd95326;
            5'd12:   recip = 19'd87382;
            5'd13:   recip = 19'd80660;
            5'd14:   recip = 19'd74899;
            5'd15:   recip = 19'd69906;
            5'd16:   recip = 19'd65536;
            default: recip = '0;
        endcase
        return recip;
    endfunction

endpackage

FILE: rtl/dcg_sector_div.sv
// registered constant dividers: sector count over 17, 31, 63 and 255
`timescale 1ns / 1ps

module dcg_sector_div
    import dcg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_en,
    input  t_sectors i_sectors,
    output t_quot    o_q17,
    output t_quot    o_q31,
    output t_quot    o_q63,
    output t_quot    o_q255,
    output logic     o_big
);

    logic [PROD_W-1:0] n_p17;
    logic [PROD_W-1:0] n_p31;
    logic [PROD_W-1:0] n_p63;
    logic [PROD_W-1:0] n_p255;

    t_quot r_q17;
    t_quot r_q31;
    t_quot r_q63;
    t_quot r_q255;
    logic  r_big;

    // reciprocal multiplies, quotient is the upper part of each product
    assign n_p17  = PROD_W'(i_sectors) * PROD_W'(RECIP_17);
    assign n_p31  = PROD_W'(i_sectors) * PROD_W'(RECIP_31);
    assign n_p63  = PROD_W'(i_sectors) * PROD_W'(RECIP_63);
    assign n_p255 = PROD_W'(i_sectors) * PROD_W'(RECIP_255);

    // quotient registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q17  <= n_p17[RECIP_SHIFT +: QUO_W];
            r_q31  <= n_p31[RECIP_SHIFT +: QUO_W];
            r_q63  <= n_p63[RECIP_SHIFT +: QUO_W];
            r_q255 <= n_p255[RECIP_SHIFT +: QUO_W];
            r_big  <= (i_sectors >= BIG_SECTORS);
        end
    end

    assign o_q17  = r_q17;
    assign o_q31  = r_q31;
    assign o_q63  = r_q63;
    assign o_q255 = r_q255;
    assign o_big  = r_big;

endmodule

FILE: rtl/disk_chs_geometry_calc.sv
// top level of the chs geometry calculator, four-stage pipeline
// order: an accepted transaction passes the sector, divider, selection and cylinder registers to reach the output
// throughput: one transaction per cycle; stages are held by a stall from downstream
// that only freezes occupied stages, so bubbles are squeezed out
// reset: synchronous active low, clears the stage valid bits only
`timescale 1ns / 1ps

module disk_chs_geometry_calc
    import dcg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_disk_size_bytes,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_cylinder_count,
    output logic [4:0]  o_head_count,
    output logic [7:0]  o_track_sectors,
    output logic [31:0] o_geometry_word
);

    localparam int unsigned SECF_W = 64 - 9;
    localparam int unsigned HSUM_W = QUO_W + 1;
    localparam int unsigned HRAW_W = HSUM_W - CPH_SHIFT;

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;

    // stall chain: a stage moves when empty or when the next one moves
    assign w_en4   = !r_v4 || !i_stall;
    assign w_en3   = !r_v3 || w_en4;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_stall = !w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    // stage 1: bytes to sectors, saturated
    logic [SECF_W-1:0] n_sec_full;
    t_sectors          n_sectors;
    t_sectors          r_sectors;

    assign n_sec_full = i_disk_size_bytes[63:9];
    assign n_sectors  = (n_sec_full > SECF_W'(MAX_SECTORS)) ? MAX_SECTORS
                                                            : n_sec_full[SEC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_en1) r_sectors <= n_sectors;
    end

    // stage 2: constant dividers
    t_quot w_q17, w_q31, w_q63, w_q255;
    logic  w_big;

    dcg_sector_div u_div (
        .i_clk    (i_clk),
        .i_en     (w_en2),
        .i_sectors(r_sectors),
        .o_q17    (w_q17),
        .o_q31    (w_q31),
        .o_q63    (w_q63),
        .o_q255   (w_q255),
        .o_big    (w_big)
    );

    // stage 3: choose sectors per track and heads
    logic [HSUM_W-1:0] n_h_sum;
    logic [HRAW_W-1:0] n_h_raw;
    logic [HRAW_W-1:0] n_h17;
    logic              n_leave17;
    logic              n_leave31;
    t_cyl_heads        n_ch;
    t_heads            n_heads;
    t_spt              n_spt;
    t_cyl_heads        r_ch;
    t_heads            r_heads;
    t_spt              r_spt;

    assign n_h_sum   = HSUM_W'(w_q17) + HSUM_W'(1023);
    assign n_h_raw   = n_h_sum[HSUM_W-1:CPH_SHIFT];
    assign n_h17     = (n_h_raw < HRAW_W'(HEADS_MIN)) ? HRAW_W'(HEADS_MIN) : n_h_raw;
    assign n_leave17 = (n_h17 > HRAW_W'(HEADS_MAX))
                    || (HSUM_W'(w_q17) >= {n_h17, {CPH_SHIFT{1'b0}}});
    assign n_leave31 = (w_q31[QUO_W-1:HCH_W] != '0);

    always_comb begin
        if (w_big) begin
            n_spt   = SPT_255;
            n_heads = HEADS_MAX;
            n_ch    = w_q255[CH_W-1:0];
        end else if (!n_leave17) begin
            n_spt   = SPT_17;
            n_heads = n_h17[HEADS_W-1:0];
            n_ch    = w_q17[CH_W-1:0];
        end else if (!n_leave31) begin
            n_spt   = SPT_31;
            n_heads = HEADS_MAX;
            n_ch    = w_q31[CH_W-1:0];
        end else begin
            n_spt   = SPT_63;
            n_heads = HEADS_MAX;
            n_ch    = w_q63[CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_ch    <= n_ch;
            r_heads <= n_heads;
            r_spt   <= n_spt;
        end
    end

    // stage 4: cylinders = cylinder-heads / heads
    logic [HPROD_W-1:0] n_hprod;
    t_cyl               n_cyl;
    t_cyl               r_cyl;
    t_heads             r_heads_o;
    t_spt               r_spt_o;

    assign n_hprod = HPROD_W'(r_ch[HCH_W-1:0]) * HPROD_W'(head_recip(r_heads));
    assign n_cyl   = (r_heads == HEADS_MAX) ? r_ch[CH_W-1:4]
                                            : CYL_W'(n_hprod >> HRECIP_SHIFT);

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_cyl     <= n_cyl;
            r_heads_o <= r_heads;
            r_spt_o   <= r_spt;
        end
    end

    // outputs
    assign o_valid          = r_v4;
    assign o_cylinder_count = r_cyl;
    assign o_head_count     = r_heads_o;
    assign o_track_sectors  = r_spt_o;
    assign o_geometry_word  = {r_cyl, 3'b000, r_heads_o, r_spt_o};

endmodule

FILE: rtl/dcg_port_checker.sv
// port-level checker for the chs geometry calculator and its bind
`timescale 1ns / 1ps

module dcg_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_cylinder_count,
    input logic [4:0]  o_head_count,
    input logic [7:0]  o_track_sectors,
    input logic [31:0] o_geometry_word
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_geometry_word))
        else $error("stalled result changed");

    // the input side only stalls when the pipe is full and the output blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked output");

    // packed word agrees with the separate fields
    a_word_pack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_geometry_word == {o_cylinder_count, 3'b000, o_head_count,
                                        o_track_sectors})
        else $error("packed word mismatch");

    // only the four track sizes appear
    a_spt_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_track_sectors == 8'd17 || o_track_sectors == 8'd31
                 || o_track_sectors == 8'd63 || o_track_sectors == 8'd255)
        else $error("illegal sectors per track");

    // heads stay in range, and all but the smallest track size use sixteen
    a_heads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_head_count >= 5'd4 && o_head_count <= 5'd16
                 && (o_track_sectors == 8'd17 || o_head_count == 5'd16))
        else $error("head count out of range");

endmodule

bind disk_chs_geometry_calc dcg_port_checker u_port_checker (.*);
